>>> design/mtg_pkg.sv
// Package: constants, types and word functions of the Mersenne Twister generator.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS);

  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC60000;
  localparam logic [31:0] UPPER_BIT    = 32'h80000000;
  localparam logic [31:0] LOWER_BITS   = 32'h7FFFFFFF;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0]      word_t;

  localparam idx_t LAST_IDX  = idx_t'(STATE_WORDS - 1);
  localparam idx_t WRAP_IDX  = idx_t'(STATE_WORDS - TWIST_OFFSET);
  localparam idx_t FAR_STEP  = idx_t'(TWIST_OFFSET);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_NEAR,
    ST_TWIST
  } mtg_state_t;

  typedef struct packed {
    logic seed_load;  // write seed at entry 0, start fill
    logic seed_step;  // write one fill word
    logic rd_first;   // read current word and far word
    logic rd_next;    // read neighbor word, hold upper bit
    logic commit;     // write twisted word, load output
  } mtg_cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_free;
  } mtg_status_t;

  function automatic word_t temper_word(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic word_t twist_word(word_t cur, word_t nbr, word_t far_w);
    word_t y;
    word_t v;
    y = (cur & UPPER_BIT) | (nbr & LOWER_BITS);
    v = far_w ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

endpackage

>>> design/mtg_if.sv
// Interfaces: input and result channels of the Mersenne Twister generator.
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

>>> design/mtg_ctrl.sv
// Controller: state machine sequencing seed fill and draw steps.
module mtg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  output logic                 in_ready,
  input  mtg_pkg::mtg_status_t status,
  output mtg_pkg::mtg_cmd_t    cmd
);
  import mtg_pkg::*;

  mtg_state_t state_r;
  mtg_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_SEED) begin
            cmd.seed_load = 1'b1;
            state_nxt     = ST_SEED;
          end else begin
            cmd.rd_first = 1'b1;
            state_nxt    = ST_NEAR;
          end
        end
      end
      ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (status.seed_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NEAR: begin
        cmd.rd_next = 1'b1;
        state_nxt   = ST_TWIST;
      end
      ST_TWIST: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/mtg_datapath.sv
// Datapath: word store, seed recurrence, on-the-fly twist, tempering and output register.
module mtg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtg_pkg::mtg_cmd_t    cmd,
  output mtg_pkg::mtg_status_t status,
  input  logic [31:0]          seed_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          random_word
);
  import mtg_pkg::*;

  word_t store_mem [STATE_WORDS];

  idx_t  pos_r;
  idx_t  pos_nxt;
  idx_t  seed_idx_r;
  word_t seed_prev_r;
  word_t rd_a_r;
  word_t rd_b_r;
  logic  upper_r;
  logic  out_valid_r;
  word_t out_word_r;

  idx_t  pos_plus1;
  idx_t  far_idx;
  idx_t  addr_a;
  idx_t  wr_addr;
  word_t wr_data;
  logic  wr_en;
  word_t seed_mix;
  word_t seed_prod;
  word_t seed_word;
  word_t twisted;

  assign pos_plus1 = (pos_r == LAST_IDX) ? '0 : pos_r + idx_t'(1);
  assign far_idx   = (pos_r >= WRAP_IDX) ? pos_r - WRAP_IDX : pos_r + FAR_STEP;
  assign addr_a    = cmd.rd_next ? pos_plus1 : pos_r;

  // fill recurrence: w[i] = M * (w[i-1] ^ (w[i-1] >> 30)) + i
  assign seed_mix  = seed_prev_r ^ (seed_prev_r >> 30);
  assign seed_prod = seed_mix * SEED_MULT;
  assign seed_word = seed_prod + word_t'(seed_idx_r);

  assign twisted = twist_word({upper_r, 31'b0}, rd_a_r, rd_b_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = twisted;
    if (cmd.seed_load) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_value;
    end else if (cmd.seed_step) begin
      wr_en   = 1'b1;
      wr_addr = seed_idx_r;
      wr_data = seed_word;
    end else if (cmd.commit) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.seed_load) begin
      pos_nxt = '0;
    end else if (cmd.commit) begin
      pos_nxt = pos_plus1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rd_a_r <= store_mem[addr_a];
    end
    if (cmd.rd_first) begin
      rd_b_r <= store_mem[far_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_next) begin
      upper_r <= rd_a_r[31];
    end
    if (cmd.seed_load) begin
      seed_prev_r <= seed_value;
    end else if (cmd.seed_step) begin
      seed_prev_r <= seed_word;
    end
    if (cmd.commit) begin
      out_word_r <= temper_word(twisted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seed_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (cmd.seed_load) begin
        seed_idx_r <= idx_t'(1);
      end else if (cmd.seed_step) begin
        seed_idx_r <= seed_idx_r + idx_t'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.seed_last = (seed_idx_r == LAST_IDX);
  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign random_word      = out_word_r;

endmodule

>>> design/mersenne_twister_generator_unit.sv
// Top level: MT19937 32-bit word generator with seed and draw transactions.
// Draw: two registered reads of the single store (current+far, then neighbor), then the
//   tempered word is registered once the output is free; no new draw is taken until then.
// Seed: all 624 store words, one written per cycle by the multiply recurrence; no result.
// Reset clears the controller, the position and the output valid; the word store
//   holds nothing defined until the first seed transaction.
module mersenne_twister_generator_unit (
  input logic       clk,
  input logic       rst_n,
  mtg_in_if.sink    in_chan,
  mtg_out_if.source out_chan
);
  import mtg_pkg::*;

  mtg_cmd_t    cmd;
  mtg_status_t status;
  logic        in_ready;
  logic        out_valid;
  word_t       random_word;

  // sequence the twist one word per draw, so each draw regenerates exactly
  // the word it returns; words behind the position are already new
  mtg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // store, recurrence, twist and tempering; output register parts the sides
  mtg_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .seed_value  (in_chan.seed_value),
    .out_valid   (out_valid),
    .out_ready   (out_chan.ready),
    .random_word (random_word)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid;
  assign out_chan.random_word = random_word;

endmodule
